// ===== hdl/rct_pkg.sv =====
package rct_pkg;

	localparam int ENTRIES_DEF     = 64;
	localparam int HANDLE_BITS_DEF = 32;

	localparam int HANDLE_W = 32;
	localparam int COUNT_W  = 16;
	localparam int STATUS_W = 3;

	localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
	localparam logic [COUNT_W-1:0] COUNT_ONE  = COUNT_W'(1);
	localparam logic [COUNT_W-1:0] COUNT_ZERO = '0;

	localparam logic MODE_ACQUIRE = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_UPDATED   = 3'd0,
		ST_INSERTED  = 3'd1,
		ST_FREED     = 3'd2,
		ST_UNKNOWN   = 3'd3,
		ST_FULL      = 3'd4,
		ST_SATURATED = 3'd5
	} status_t;

	typedef struct packed {
		logic                mode;
		logic [HANDLE_W-1:0] handle;
	} req_item_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle_out;
		logic [COUNT_W-1:0]  count_after;
		status_t             status;
	} res_item_t;

endpackage

// ===== hdl/rct_table.sv =====
module rct_table #(
	parameter int ENTRIES     = rct_pkg::ENTRIES_DEF,
	parameter int HANDLE_BITS = rct_pkg::HANDLE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                commit,
	input  rct_pkg::req_item_t  item,
	output rct_pkg::res_item_t  result
);

	localparam int HW    = rct_pkg::HANDLE_W;
	localparam int CW    = rct_pkg::COUNT_W;
	localparam int KEY_W = (HANDLE_BITS < HW) ? HANDLE_BITS : HW;

	logic [KEY_W-1:0]   handle_q [ENTRIES];
	logic [CW-1:0]      count_q  [ENTRIES];
	logic [ENTRIES-1:0] valid_q;

	logic [KEY_W-1:0]   key;
	logic               release_req;
	logic [ENTRIES-1:0] match;
	logic [ENTRIES-1:0] hit_oh;
	logic [ENTRIES-1:0] free_vec;
	logic [ENTRIES-1:0] free_oh;
	logic               any_hit;
	logic               any_free;
	logic [CW-1:0]      hit_count;
	logic [CW-1:0]      new_count;
	rct_pkg::status_t   status;
	logic               do_insert;
	logic               do_free;
	logic               do_count;

	assign key         = item.handle[KEY_W-1:0];
	assign release_req = (item.mode == rct_pkg::MODE_RELEASE);

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (handle_q[i] == key);
		end
	end

	// isolate lowest set bit: lowest index wins on duplicates and on insert
	assign free_vec = ~valid_q;
	assign hit_oh   = match & (~match + {{(ENTRIES-1){1'b0}}, 1'b1});
	assign free_oh  = free_vec & (~free_vec + {{(ENTRIES-1){1'b0}}, 1'b1});
	assign any_hit  = |match;
	assign any_free = |free_vec;

	always_comb begin
		hit_count = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_count = hit_count | (count_q[i] & {CW{hit_oh[i]}});
		end
	end

	always_comb begin
		new_count = rct_pkg::COUNT_ZERO;
		status    = rct_pkg::ST_UNKNOWN;
		do_insert = 1'b0;
		do_free   = 1'b0;
		do_count  = 1'b0;
		if (any_hit) begin
			if (!release_req) begin
				if (hit_count == rct_pkg::COUNT_MAX) begin
					new_count = rct_pkg::COUNT_MAX;
					status    = rct_pkg::ST_SATURATED;
				end else begin
					new_count = hit_count + rct_pkg::COUNT_ONE;
					status    = rct_pkg::ST_UPDATED;
					do_count  = 1'b1;
				end
			end else if (hit_count <= rct_pkg::COUNT_ONE) begin
				status  = rct_pkg::ST_FREED;
				do_free = 1'b1;
			end else begin
				new_count = hit_count - rct_pkg::COUNT_ONE;
				status    = rct_pkg::ST_UPDATED;
				do_count  = 1'b1;
			end
		end else if (release_req) begin
			status = rct_pkg::ST_UNKNOWN;
		end else if (!any_free) begin
			status = rct_pkg::ST_FULL;
		end else begin
			new_count = rct_pkg::COUNT_ONE;
			status    = rct_pkg::ST_INSERTED;
			do_insert = 1'b1;
		end
	end

	always_comb begin
		result.handle_out             = '0;
		result.handle_out[KEY_W-1:0]  = key;
		result.count_after            = new_count;
		result.status                 = status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (commit) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (do_free && hit_oh[i]) begin
					valid_q[i] <= 1'b0;
				end
				if (do_insert && free_oh[i]) begin
					valid_q[i] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (do_count && hit_oh[i]) begin
					count_q[i] <= new_count;
				end
				if (do_insert && free_oh[i]) begin
					handle_q[i] <= key;
					count_q[i]  <= rct_pkg::COUNT_ONE;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_full_means_all_valid: assert property (@(posedge clk) disable iff (!arst_n)
		commit && (status == rct_pkg::ST_FULL) |-> (&valid_q))
		else $error("table reported full with a free entry");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		commit && (status == rct_pkg::ST_INSERTED)
		|=> ($countones(valid_q) == $countones($past(valid_q)) + 1))
		else $error("insert did not add exactly one entry");

	a_free_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		commit && (status == rct_pkg::ST_FREED)
		|=> ($countones(valid_q) + 1 == $countones($past(valid_q))))
		else $error("free did not remove exactly one entry");

	a_no_change_keeps_valid: assert property (@(posedge clk) disable iff (!arst_n)
		commit && (status == rct_pkg::ST_UNKNOWN || status == rct_pkg::ST_FULL ||
		status == rct_pkg::ST_SATURATED || status == rct_pkg::ST_UPDATED)
		|=> $stable(valid_q))
		else $error("entry set changed on a non-inserting, non-freeing request");
`endif

endmodule

// ===== hdl/reference_count_table.sv =====
// Channel   | valid     | stall     | payload                          | direction
// ----------+-----------+-----------+----------------------------------+----------
// request   | req_valid | req_stall | req (mode, handle)               | in
// result    | res_valid | res_stall | res (handle_out, count_after,    | out
//           |           |           |      status)                     |
//
// One request per cycle sustained while the result is not stalled; each
// request taken sits in the input register for its lookup, then its result
// lands in the result register.
// The combinational path is the associative compare over all entries plus one
// count increment or decrement, written back at the same edge as the result.
// Reset clears the valid bits at once; no clearing pass, requests are taken
// from the first cycle after reset.
// A stalled result holds the input register; req_stall rises once it holds a request.
module reference_count_table #(
	parameter int ENTRIES     = rct_pkg::ENTRIES_DEF,
	parameter int HANDLE_BITS = rct_pkg::HANDLE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  rct_pkg::req_item_t req,
	output logic               res_valid,
	input  logic               res_stall,
	output rct_pkg::res_item_t res
);

	// input register: the request under lookup
	logic               valid_s1;
	rct_pkg::req_item_t req_s1;

	// result register
	logic               valid_s2;
	rct_pkg::res_item_t res_s2;

	logic               advance;
	logic               commit;
	rct_pkg::res_item_t lookup;

	// Advance when the result register is empty or being drained this cycle.
	assign advance   = !valid_s2 || !res_stall;
	// Commit the table update only when the result has a place to go, so the
	// table never runs ahead of the results delivered.
	assign commit    = valid_s1 && advance;
	assign req_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Load payload on accept; hold otherwise.
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	rct_table #(
		.ENTRIES     (ENTRIES),
		.HANDLE_BITS (HANDLE_BITS)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (commit),
		.item   (req_s1),
		.result (lookup)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	// Capture the lookup outcome in the same edge that writes the table.
	always_ff @(posedge clk) begin
		if (commit) begin
			res_s2 <= lookup;
		end
	end

	assign res_valid = valid_s2;
	assign res       = res_s2;

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (valid_s1 && valid_s2 && res_stall))
		else $error("request stalled while the pipeline could move");

	a_commit_fills_result: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> res_valid)
		else $error("committed request produced no result");

	a_stalled_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result changed");
`endif

endmodule
